// ----- hw/rtl/tmoire_pkg.sv -----
`timescale 1ns / 1ps

package tmoire_pkg;

  localparam int COORD_W    = 11;  // column / row
  localparam int FRAME_W    = 12;  // frame width / height
  localparam int CENTRE_W   = 20;  // ring centre, 8 fraction bits
  localparam int SCALE_W    = 17;  // ring frequency
  localparam int FRAC_BITS  = 8;
  localparam int POS_W      = 21;  // pixel position about the frame centre
  localparam int DIFF_W     = 22;  // position minus ring centre
  localparam int OFS_W      = 18;  // offset after the shift by 4
  localparam int OFS_SHIFT  = 4;
  localparam int SQ_W       = 33;  // one squared offset
  localparam int SUM_W      = 34;  // sum of both squares
  localparam int SUMQ_W     = SUM_W - FRAC_BITS;       // sum >> 8
  localparam int SQ_IN_W    = SUMQ_W + 2 * FRAC_BITS;  // radicand
  localparam int ROOT_W     = SQ_IN_W / 2;             // distance
  localparam int REM_W      = ROOT_W + 2;              // partial remainder
  localparam int PROD_W     = ROOT_W + SCALE_W;
  localparam int GREY_W     = 8;
  localparam int COLOUR_W   = 3 * GREY_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_ONE_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_ONE_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_TWO_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_TWO_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RING_SCALE_ONE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RING_SCALE_TWO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd7;

  localparam logic signed [CENTRE_W-1:0] RST_CENTRE_ONE_X = 20'sd0;
  localparam logic signed [CENTRE_W-1:0] RST_CENTRE_ONE_Y = 20'sd0;
  localparam logic signed [CENTRE_W-1:0] RST_CENTRE_TWO_X = 20'sd3276;
  localparam logic signed [CENTRE_W-1:0] RST_CENTRE_TWO_Y = 20'sd2457;
  localparam logic [SCALE_W-1:0]         RST_RING_SCALE   = 17'd16384;
  localparam logic [FRAME_W-1:0]         RST_FRAME_WIDTH  = 12'd640;
  localparam logic [FRAME_W-1:0]         RST_FRAME_HEIGHT = 12'd480;

endpackage

// ----- hw/rtl/tmoire_front.sv -----
`timescale 1ns / 1ps

// Offset, square and sum for one ring: three register stages.
module tmoire_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_vld,
  input  logic signed [tmoire_pkg::POS_W-1:0]  px,
  input  logic signed [tmoire_pkg::POS_W-1:0]  py,
  input  logic signed [tmoire_pkg::CENTRE_W-1:0] cx,
  input  logic signed [tmoire_pkg::CENTRE_W-1:0] cy,
  output logic                                 out_vld,
  output logic [tmoire_pkg::SUMQ_W-1:0]        sum_q
);

  logic signed [tmoire_pkg::DIFF_W-1:0]  diff_x;
  logic signed [tmoire_pkg::DIFF_W-1:0]  diff_y;
  logic signed [2*tmoire_pkg::OFS_W-1:0] prod_x;
  logic signed [2*tmoire_pkg::OFS_W-1:0] prod_y;
  logic [tmoire_pkg::SUM_W-1:0]          sum_full;

  logic                                  vld1;
  logic                                  vld2;
  logic signed [tmoire_pkg::OFS_W-1:0]   ofs_x;
  logic signed [tmoire_pkg::OFS_W-1:0]   ofs_y;
  logic [tmoire_pkg::SQ_W-1:0]           sq_x;
  logic [tmoire_pkg::SQ_W-1:0]           sq_y;

  assign diff_x = {px[tmoire_pkg::POS_W-1], px}
                - {{(tmoire_pkg::DIFF_W - tmoire_pkg::CENTRE_W){cx[tmoire_pkg::CENTRE_W-1]}}, cx};
  assign diff_y = {py[tmoire_pkg::POS_W-1], py}
                - {{(tmoire_pkg::DIFF_W - tmoire_pkg::CENTRE_W){cy[tmoire_pkg::CENTRE_W-1]}}, cy};

  assign prod_x   = ofs_x * ofs_x;
  assign prod_y   = ofs_y * ofs_y;
  assign sum_full = {1'b0, sq_x} + {1'b0, sq_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    // arithmetic shift gives the floor of the division by 16
    ofs_x <= diff_x[tmoire_pkg::DIFF_W-1:tmoire_pkg::OFS_SHIFT];
    ofs_y <= diff_y[tmoire_pkg::DIFF_W-1:tmoire_pkg::OFS_SHIFT];
    sq_x  <= prod_x[tmoire_pkg::SQ_W-1:0];
    sq_y  <= prod_y[tmoire_pkg::SQ_W-1:0];
    sum_q <= sum_full[tmoire_pkg::SUM_W-1:tmoire_pkg::FRAC_BITS];
  end

endmodule

// ----- hw/rtl/tmoire_sqrt.sv -----
`timescale 1ns / 1ps

// Pipelined integer square root: one root bit per stage.
module tmoire_sqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_vld,
  input  logic [tmoire_pkg::SQ_IN_W-1:0]   radicand,
  output logic                             out_vld,
  output logic [tmoire_pkg::ROOT_W-1:0]    root
);

  localparam int NSTG = tmoire_pkg::ROOT_W;

  logic                            cur_vld  [0:NSTG-1];
  logic [tmoire_pkg::SQ_IN_W-1:0]  cur_rad  [0:NSTG-1];
  logic [tmoire_pkg::ROOT_W-1:0]   cur_root [0:NSTG-1];
  logic [tmoire_pkg::REM_W-1:0]    cur_rem  [0:NSTG-1];

  logic [tmoire_pkg::SQ_IN_W-1:0]  nxt_rad  [0:NSTG-1];
  logic [tmoire_pkg::ROOT_W-1:0]   nxt_root [0:NSTG-1];
  logic [tmoire_pkg::REM_W-1:0]    nxt_rem  [0:NSTG-1];

  logic                            st_vld   [0:NSTG-1];
  logic [tmoire_pkg::SQ_IN_W-1:0]  st_rad   [0:NSTG-1];
  logic [tmoire_pkg::ROOT_W-1:0]   st_root  [0:NSTG-1];
  logic [tmoire_pkg::REM_W-1:0]    st_rem   [0:NSTG-1];

  always_comb begin
    cur_vld[0]  = in_vld;
    cur_rad[0]  = radicand;
    cur_root[0] = '0;
    cur_rem[0]  = '0;
    for (int k = 1; k < NSTG; k++) begin
      cur_vld[k]  = st_vld[k-1];
      cur_rad[k]  = st_rad[k-1];
      cur_root[k] = st_root[k-1];
      cur_rem[k]  = st_rem[k-1];
    end
  end

  // bring down the next two radicand bits, try (root << 2) | 1
  always_comb begin
    logic [tmoire_pkg::REM_W-1:0] trial_rem;
    logic [tmoire_pkg::REM_W-1:0] trial_sub;
    for (int k = 0; k < NSTG; k++) begin
      trial_rem = {cur_rem[k][tmoire_pkg::REM_W-3:0],
                   cur_rad[k][tmoire_pkg::SQ_IN_W-1 -: 2]};
      trial_sub = {cur_root[k], 2'b01};
      nxt_rad[k] = cur_rad[k] << 2;
      if (trial_rem >= trial_sub) begin
        nxt_rem[k]  = trial_rem - trial_sub;
        nxt_root[k] = {cur_root[k][tmoire_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        nxt_rem[k]  = trial_rem;
        nxt_root[k] = {cur_root[k][tmoire_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTG; k++) begin
        st_vld[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        st_vld[k] <= cur_vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      st_rad[k]  <= nxt_rad[k];
      st_root[k] <= nxt_root[k];
      st_rem[k]  <= nxt_rem[k];
    end
  end

  assign out_vld = st_vld[NSTG-1];
  assign root    = st_root[NSTG-1];

  // the remainder of a finished root never exceeds twice the root
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> (st_rem[NSTG-1] <= {1'b0, root, 1'b0}))
    else $error("sqrt remainder out of range");

  a_rst_flush: assert property (@(posedge clk)
    rst |=> !out_vld)
    else $error("sqrt word survived reset");

endmodule

// ----- hw/rtl/tmoire_wave.sv -----
`timescale 1ns / 1ps

// Ring scale multiply, then triangle wave on the low 8 bits of the ring index.
module tmoire_wave (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_vld,
  input  logic [tmoire_pkg::ROOT_W-1:0]   distance,
  input  logic [tmoire_pkg::SCALE_W-1:0]  scale,
  output logic                            out_vld,
  output logic [tmoire_pkg::GREY_W-1:0]   grey
);

  localparam logic [16:0] TRI_SLOPE = 17'd510;

  logic [tmoire_pkg::PROD_W-1:0]  prod;
  logic                           vld1;
  logic [tmoire_pkg::GREY_W-1:0]  phase;
  logic [16:0]                    ramp;
  logic [tmoire_pkg::GREY_W-1:0]  tri_val;

  assign prod = {{tmoire_pkg::SCALE_W{1'b0}}, distance} * {{tmoire_pkg::ROOT_W{1'b0}}, scale};

  // rising half uses the phase itself, falling half the phase past 128
  assign ramp    = TRI_SLOPE * {10'd0, phase[6:0]};
  assign tri_val = phase[7] ? (8'd255 - ramp[15:8]) : ramp[15:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    phase <= prod[2*tmoire_pkg::FRAC_BITS +: tmoire_pkg::GREY_W];
    grey  <= tri_val;
  end

endmodule

// ----- hw/rtl/two_ring_moire_pixel_generator_unit.sv -----
`timescale 1ns / 1ps

// Two-ring moire pixel generator. A pixel (column, row) is taken on every
// clock at which start is high; busy never rises, so one pixel per clock is
// sustained. Each colour word appears on colour with done high for one cycle,
// in the order the pixels went in; the receiver cannot hold it off. Pixels
// pass the position, offset, square and sum stages, the 21-stage square root
// (one root bit per stage), then the scale, triangle and output stages.
// Registers are written through wr_en, wr_index and wr_data; the user must
// write them only while no pixel is in flight; the block leaves it unchecked.
module two_ring_moire_pixel_generator_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [tmoire_pkg::COORD_W-1:0]      column,
  input  logic [tmoire_pkg::COORD_W-1:0]      row,
  output logic                                done,
  output logic [tmoire_pkg::COLOUR_W-1:0]     colour,
  input  logic                                wr_en,
  input  logic [tmoire_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [tmoire_pkg::CFG_DATA_W-1:0]   wr_data
);

  logic signed [tmoire_pkg::CENTRE_W-1:0] centre_one_x;
  logic signed [tmoire_pkg::CENTRE_W-1:0] centre_one_y;
  logic signed [tmoire_pkg::CENTRE_W-1:0] centre_two_x;
  logic signed [tmoire_pkg::CENTRE_W-1:0] centre_two_y;
  logic [tmoire_pkg::SCALE_W-1:0]         ring_scale_one;
  logic [tmoire_pkg::SCALE_W-1:0]         ring_scale_two;
  logic [tmoire_pkg::FRAME_W-1:0]         frame_width;
  logic [tmoire_pkg::FRAME_W-1:0]         frame_height;

  logic                                   pos_vld;
  logic signed [tmoire_pkg::POS_W-1:0]    pos_x;
  logic signed [tmoire_pkg::POS_W-1:0]    pos_y;
  logic signed [tmoire_pkg::POS_W-1:0]    pos_x_next;
  logic signed [tmoire_pkg::POS_W-1:0]    pos_y_next;

  logic                                   sum1_vld;
  logic                                   sum2_vld;
  logic [tmoire_pkg::SUMQ_W-1:0]          sum1;
  logic [tmoire_pkg::SUMQ_W-1:0]          sum2;
  logic                                   dist1_vld;
  logic                                   dist2_vld;
  logic [tmoire_pkg::ROOT_W-1:0]          dist1;
  logic [tmoire_pkg::ROOT_W-1:0]          dist2;
  logic                                   grey1_vld;
  logic                                   grey2_vld;
  logic [tmoire_pkg::GREY_W-1:0]          grey1;
  logic [tmoire_pkg::GREY_W-1:0]          grey2;
  logic [tmoire_pkg::GREY_W-1:0]          grey_diff;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_one_x   <= tmoire_pkg::RST_CENTRE_ONE_X;
      centre_one_y   <= tmoire_pkg::RST_CENTRE_ONE_Y;
      centre_two_x   <= tmoire_pkg::RST_CENTRE_TWO_X;
      centre_two_y   <= tmoire_pkg::RST_CENTRE_TWO_Y;
      ring_scale_one <= tmoire_pkg::RST_RING_SCALE;
      ring_scale_two <= tmoire_pkg::RST_RING_SCALE;
      frame_width    <= tmoire_pkg::RST_FRAME_WIDTH;
      frame_height   <= tmoire_pkg::RST_FRAME_HEIGHT;
    end else if (wr_en) begin
      case (wr_index)
        tmoire_pkg::REG_CENTRE_ONE_X:   centre_one_x   <= wr_data;
        tmoire_pkg::REG_CENTRE_ONE_Y:   centre_one_y   <= wr_data;
        tmoire_pkg::REG_CENTRE_TWO_X:   centre_two_x   <= wr_data;
        tmoire_pkg::REG_CENTRE_TWO_Y:   centre_two_y   <= wr_data;
        tmoire_pkg::REG_RING_SCALE_ONE: ring_scale_one <= wr_data[tmoire_pkg::SCALE_W-1:0];
        tmoire_pkg::REG_RING_SCALE_TWO: ring_scale_two <= wr_data[tmoire_pkg::SCALE_W-1:0];
        tmoire_pkg::REG_FRAME_WIDTH:    frame_width    <= wr_data[tmoire_pkg::FRAME_W-1:0];
        tmoire_pkg::REG_FRAME_HEIGHT:   frame_height   <= wr_data[tmoire_pkg::FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // position about the frame centre: coord * 256 - size * 128
  assign pos_x_next = {2'b00, column, 8'd0} - {2'b00, frame_width, 7'd0};
  assign pos_y_next = {2'b00, row, 8'd0} - {2'b00, frame_height, 7'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_vld <= 1'b0;
    end else begin
      pos_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    pos_x <= pos_x_next;
    pos_y <= pos_y_next;
  end

  tmoire_front u_front1 (
    .clk(clk), .rst(rst), .in_vld(pos_vld), .px(pos_x), .py(pos_y),
    .cx(centre_one_x), .cy(centre_one_y), .out_vld(sum1_vld), .sum_q(sum1)
  );

  tmoire_front u_front2 (
    .clk(clk), .rst(rst), .in_vld(pos_vld), .px(pos_x), .py(pos_y),
    .cx(centre_two_x), .cy(centre_two_y), .out_vld(sum2_vld), .sum_q(sum2)
  );

  tmoire_sqrt u_sqrt1 (
    .clk(clk), .rst(rst), .in_vld(sum1_vld),
    .radicand({sum1, {(2 * tmoire_pkg::FRAC_BITS){1'b0}}}),
    .out_vld(dist1_vld), .root(dist1)
  );

  tmoire_sqrt u_sqrt2 (
    .clk(clk), .rst(rst), .in_vld(sum2_vld),
    .radicand({sum2, {(2 * tmoire_pkg::FRAC_BITS){1'b0}}}),
    .out_vld(dist2_vld), .root(dist2)
  );

  tmoire_wave u_wave1 (
    .clk(clk), .rst(rst), .in_vld(dist1_vld), .distance(dist1), .scale(ring_scale_one),
    .out_vld(grey1_vld), .grey(grey1)
  );

  tmoire_wave u_wave2 (
    .clk(clk), .rst(rst), .in_vld(dist2_vld), .distance(dist2), .scale(ring_scale_two),
    .out_vld(grey2_vld), .grey(grey2)
  );

  assign grey_diff = (grey1 > grey2) ? (grey1 - grey2) : (grey2 - grey1);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= grey1_vld;
    end
  end

  always_ff @(posedge clk) begin
    colour <= {grey_diff, grey_diff, grey_diff};
  end

  // both ring paths have equal depth, so their valid bits move in lockstep
  a_ring_lockstep: assert property (@(posedge clk) disable iff (rst)
    grey1_vld == grey2_vld)
    else $error("ring pipelines out of step");

  a_grey_channels: assert property (@(posedge clk) disable iff (rst)
    done |-> (colour[23:16] == colour[15:8]) && (colour[15:8] == colour[7:0]))
    else $error("colour channels differ");

endmodule
